>>> design/sdh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_pkg: shared types, constants and functions of the stick deadzone block
// Axis rescale helpers, pipelined division step and hat encoder.
// ----------------------------------------------------------------------------
package sdh_pkg;

    // Field widths
    localparam int AXIS_W      = 8;
    localparam int CFG_W       = 7;
    localparam int HAT_W       = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int NUM_W       = 16;
    localparam int Q_W         = 8;
    localparam int SCALE_SHIFT = 7;           // upper span 255 - 127 = 128
    localparam int DIV_STAGES  = Q_W / 2;     // two quotient bits per stage
    localparam int NUM_STAGES  = DIV_STAGES + 2;

    localparam logic [AXIS_W-1:0] AXIS_CENTRE = 8'd127;
    localparam logic [AXIS_W-1:0] AXIS_FULL   = 8'd255;

    // Register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HAT_THRESHOLD = 4'd1;
    localparam logic [CFG_W-1:0] DEADZONE_RESET      = 7'd50;
    localparam logic [CFG_W-1:0] HAT_THRESHOLD_RESET = 7'd50;

    // Direction bits
    localparam logic [3:0] DIR_UP    = 4'b0001;
    localparam logic [3:0] DIR_DOWN  = 4'b0010;
    localparam logic [3:0] DIR_LEFT  = 4'b0100;
    localparam logic [3:0] DIR_RIGHT = 4'b1000;

    // Hat codes
    localparam logic [HAT_W-1:0] HAT_N    = 4'd0;
    localparam logic [HAT_W-1:0] HAT_NE   = 4'd1;
    localparam logic [HAT_W-1:0] HAT_E    = 4'd2;
    localparam logic [HAT_W-1:0] HAT_SE   = 4'd3;
    localparam logic [HAT_W-1:0] HAT_S    = 4'd4;
    localparam logic [HAT_W-1:0] HAT_SW   = 4'd5;
    localparam logic [HAT_W-1:0] HAT_W_   = 4'd6;
    localparam logic [HAT_W-1:0] HAT_NW   = 4'd7;
    localparam logic [HAT_W-1:0] HAT_NONE = 4'd15;

    typedef enum logic [1:0] {
        AXIS_CENTRED,
        AXIS_ABOVE,
        AXIS_BELOW
    } axis_mode_t;

    // One axis in flight through the divider
    typedef struct packed {
        axis_mode_t        mode;
        logic [NUM_W-1:0]  rem;
        logic [AXIS_W-1:0] den;
        logic [Q_W-1:0]    quo;
    } axis_div_t;

    // One sample pair in flight
    typedef struct packed {
        axis_div_t         a;
        axis_div_t         b;
        logic [HAT_W-1:0]  hat;
    } lane_t;

    // Classify an axis and set up numerator and divisor
    function automatic axis_div_t axis_prep(logic [AXIS_W-1:0] x, logic [CFG_W-1:0] dz);
        axis_div_t         r;
        logic [AXIS_W-1:0] hi;
        logic [AXIS_W-1:0] lo;
        logic [AXIS_W-1:0] diff;
        hi     = AXIS_CENTRE + AXIS_W'(dz);
        lo     = AXIS_CENTRE - AXIS_W'(dz);
        r.mode = AXIS_CENTRED;
        r.rem  = '0;
        r.den  = '0;
        r.quo  = '0;
        if (x > hi)
        begin
            diff   = x - hi;
            r.mode = AXIS_ABOVE;
            r.rem  = NUM_W'(diff) << SCALE_SHIFT;
            r.den  = AXIS_FULL - hi;
        end
        else if (x < lo)
        begin
            // times 127 as times 128 less one
            diff   = lo - x;
            r.mode = AXIS_BELOW;
            r.rem  = (NUM_W'(diff) << SCALE_SHIFT) - NUM_W'(diff);
            r.den  = lo;
        end
        return r;
    endfunction

    // One restoring division step for quotient bit bit_pos
    function automatic axis_div_t div_step(axis_div_t s, logic [2:0] bit_pos);
        axis_div_t        r;
        logic [NUM_W-1:0] sub;
        r   = s;
        sub = NUM_W'(s.den) << bit_pos;
        if (s.rem >= sub)
        begin
            r.rem          = s.rem - sub;
            r.quo[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    // Final value from mode and quotient
    function automatic logic [AXIS_W-1:0] axis_finish(axis_div_t s);
        logic [AXIS_W-1:0] v;
        case (s.mode)
            AXIS_ABOVE: v = AXIS_CENTRE + s.quo;
            AXIS_BELOW: v = AXIS_CENTRE - s.quo;
            default:    v = AXIS_CENTRE;
        endcase
        return v;
    endfunction

    // Map direction bits to a hat code
    function automatic logic [HAT_W-1:0] hat_lookup(logic [3:0] bits);
        logic [HAT_W-1:0] h;
        case (bits)
            DIR_UP:               h = HAT_N;
            DIR_UP | DIR_RIGHT:   h = HAT_NE;
            DIR_RIGHT:            h = HAT_E;
            DIR_DOWN | DIR_RIGHT: h = HAT_SE;
            DIR_DOWN:             h = HAT_S;
            DIR_DOWN | DIR_LEFT:  h = HAT_SW;
            DIR_LEFT:             h = HAT_W_;
            DIR_UP | DIR_LEFT:    h = HAT_NW;
            default:              h = HAT_NONE;
        endcase
        return h;
    endfunction

    // Compare raw axes against centre plus or minus threshold
    function automatic logic [HAT_W-1:0] hat_encode(logic [AXIS_W-1:0] a,
                                                    logic [AXIS_W-1:0] b,
                                                    logic [CFG_W-1:0] thr);
        logic [AXIS_W:0]   up_lim;
        logic [AXIS_W-1:0] dn_lim;
        logic [3:0]        bits;
        up_lim = {1'b0, AXIS_CENTRE} + (AXIS_W+1)'(thr);
        dn_lim = AXIS_CENTRE - AXIS_W'(thr);
        bits   = '0;
        if ({1'b0, a} > up_lim)
        begin
            bits = bits | DIR_UP;
        end
        else if (a < dn_lim)
        begin
            bits = bits | DIR_DOWN;
        end
        if ({1'b0, b} > up_lim)
        begin
            bits = bits | DIR_LEFT;
        end
        else if (b < dn_lim)
        begin
            bits = bits | DIR_RIGHT;
        end
        return hat_lookup(bits);
    endfunction

endpackage
`default_nettype wire

>>> design/sdh_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_if: request channels of the stick deadzone block
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdh_sample_if;
    logic                          valid;
    logic                          ready;
    logic [sdh_pkg::AXIS_W-1:0]    axis_a;
    logic [sdh_pkg::AXIS_W-1:0]    axis_b;

    modport source (output valid, output axis_a, output axis_b, input ready);
    modport sink   (input valid, input axis_a, input axis_b, output ready);
endinterface

interface sdh_result_if;
    logic                          valid;
    logic                          ready;
    logic [sdh_pkg::AXIS_W-1:0]    value_a;
    logic [sdh_pkg::AXIS_W-1:0]    value_b;
    logic [sdh_pkg::HAT_W-1:0]     hat_code;

    modport source (output valid, output value_a, output value_b, output hat_code,
                    input ready);
    modport sink   (input valid, input value_a, input value_b, input hat_code,
                    output ready);
endinterface

interface sdh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sdh_pkg::CFG_INDEX_W-1:0] index;
    logic [sdh_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/stick_deadzone_and_hat.sv
`default_nettype none
// Throughput: one sample pair per cycle unless the result side stalls. The
// divider runs two quotient bits in each of four stages, so the six-stage
// pipeline never stops on its own.
// Backpressure fills bubbles first; input is refused only when all stages hold.
// Reset: valid bits clear, deadzone and hat threshold return to 50.
// ----------------------------------------------------------------------------
// stick_deadzone_and_hat: thumbstick deadzone rescaler and hat encoder
// Per axis deadzone, rescale by pipelined division, and 8-way hat code.
// ----------------------------------------------------------------------------
module stick_deadzone_and_hat (
    input  wire          clk,
    input  wire          rst_n,
    sdh_sample_if.sink   sample,
    sdh_result_if.source result,
    sdh_cfg_if.sink      cfg
);

    localparam int NS = sdh_pkg::NUM_STAGES;
    localparam int ND = sdh_pkg::DIV_STAGES;

    logic [sdh_pkg::CFG_W-1:0]  deadzone_reg;
    logic [sdh_pkg::CFG_W-1:0]  hat_threshold_reg;
    logic [NS-1:0]              valid_reg;
    logic [NS-1:0]              stage_ready;
    sdh_pkg::lane_t             pipe_reg [0:ND];
    logic [sdh_pkg::AXIS_W-1:0] value_a_reg;
    logic [sdh_pkg::AXIS_W-1:0] value_b_reg;
    logic [sdh_pkg::HAT_W-1:0]  hat_code_reg;

    // Take register writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg      <= sdh_pkg::DEADZONE_RESET;
            hat_threshold_reg <= sdh_pkg::HAT_THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == sdh_pkg::REG_DEADZONE)
            begin
                deadzone_reg <= cfg.data;
            end
            else if (cfg.index == sdh_pkg::REG_HAT_THRESHOLD)
            begin
                hat_threshold_reg <= cfg.data;
            end
        end
    end

    // Ready chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign sample.ready = stage_ready[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: classify axes, set up division, encode the hat
    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && sample.valid)
        begin
            pipe_reg[0].a   <= sdh_pkg::axis_prep(sample.axis_a, deadzone_reg);
            pipe_reg[0].b   <= sdh_pkg::axis_prep(sample.axis_b, deadzone_reg);
            pipe_reg[0].hat <= sdh_pkg::hat_encode(sample.axis_a, sample.axis_b,
                                                   hat_threshold_reg);
        end
    end

    // Stages 1 to ND: two quotient bits each, highest first
    for (genvar k = 1; k <= ND; k++)
    begin : g_div
        localparam int HI_BIT = sdh_pkg::Q_W + 1 - 2 * k;

        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && valid_reg[k-1])
            begin
                pipe_reg[k].a   <= sdh_pkg::div_step(
                                       sdh_pkg::div_step(pipe_reg[k-1].a, 3'(HI_BIT)),
                                       3'(HI_BIT - 1));
                pipe_reg[k].b   <= sdh_pkg::div_step(
                                       sdh_pkg::div_step(pipe_reg[k-1].b, 3'(HI_BIT)),
                                       3'(HI_BIT - 1));
                pipe_reg[k].hat <= pipe_reg[k-1].hat;
            end
        end
    end

    // Output stage: apply quotient around centre
    always_ff @(posedge clk)
    begin
        if (stage_ready[NS-1] && valid_reg[NS-2])
        begin
            value_a_reg  <= sdh_pkg::axis_finish(pipe_reg[ND].a);
            value_b_reg  <= sdh_pkg::axis_finish(pipe_reg[ND].b);
            hat_code_reg <= pipe_reg[ND].hat;
        end
    end

    assign result.valid    = valid_reg[NS-1];
    assign result.value_a  = value_a_reg;
    assign result.value_b  = value_b_reg;
    assign result.hat_code = hat_code_reg;

    // Any empty stage must let a new request in
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) < NS) |-> sample.ready)
        else $error("input refused while the pipeline has a free stage");

    // Quotient stays within the axis span on the upper branch
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ND] && pipe_reg[ND].a.mode == sdh_pkg::AXIS_ABOVE)
            |-> (pipe_reg[ND].a.quo <= 8'd128))
        else $error("upper rescale quotient out of range");

    // Quotient stays within the axis span on the lower branch
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ND] && pipe_reg[ND].b.mode == sdh_pkg::AXIS_BELOW)
            |-> (pipe_reg[ND].b.quo <= 8'd127))
        else $error("lower rescale quotient out of range");

    // A held result's value_a and hat code must not move while the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(value_a_reg)
            && $stable(hat_code_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

>>> sim/stick_deadzone_and_hat_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_deadzone_and_hat_test: self-checking bench of the stick deadzone block
// Walks a table of directed requests and register writes. It then runs random
// phases with new register settings, random idling on both sides and one long
// hold-off of the result side. Every result is checked against a typed or predicted expectation.
// ----------------------------------------------------------------------------
module stick_deadzone_and_hat_test;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_ROWS        = 27;
    localparam int NUM_PHASES      = 6;
    localparam int PHASE_ITEMS     = 100;
    localparam int MAX_GAP         = 10;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int TAIL_CYCLES     = 12;
    localparam int CFG_MAX         = 127;

    // Highest index that the block ignores
    localparam logic [sdh_pkg::CFG_INDEX_W-1:0] REG_SPARE = 4'd15;

    typedef struct packed {
        logic [sdh_pkg::AXIS_W-1:0] value_a;
        logic [sdh_pkg::AXIS_W-1:0] value_b;
        logic [sdh_pkg::HAT_W-1:0]  hat_code;
    } stick_out_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [sdh_pkg::CFG_INDEX_W-1:0] index;
        logic [sdh_pkg::CFG_W-1:0]       data;
        logic [sdh_pkg::AXIS_W-1:0]      axis_a;
        logic [sdh_pkg::AXIS_W-1:0]      axis_b;
        logic                            typed;
        stick_out_t                      want;
    } row_t;

    logic clk;
    logic rst_n;

    sdh_sample_if sample_ch ();
    sdh_result_if result_ch ();
    sdh_cfg_if    cfg_ch ();

    stick_deadzone_and_hat uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    stick_out_t                pending_outputs[$];
    logic [sdh_pkg::CFG_W-1:0] shadow_deadzone  = sdh_pkg::DEADZONE_RESET;
    logic [sdh_pkg::CFG_W-1:0] shadow_threshold = sdh_pkg::HAT_THRESHOLD_RESET;
    int                        fail_count       = 0;
    int                        cycle_count      = 0;
    logic                      quiet_tx         = 1'b0;
    logic                      quiet_rx         = 1'b0;
    logic                      hold_off_go      = 1'b0;
    row_t                      plan [NUM_ROWS];

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Rescale one axis around the centre, outside the deadzone
    function automatic logic [sdh_pkg::AXIS_W-1:0] shape_axis(
            logic [sdh_pkg::AXIS_W-1:0] x,
            logic [sdh_pkg::CFG_W-1:0] dz);
        int xi;
        int hi;
        int lo;
        int span;
        xi = int'(x);
        hi = int'(sdh_pkg::AXIS_CENTRE) + int'(dz);
        lo = int'(sdh_pkg::AXIS_CENTRE) - int'(dz);
        if (xi >= lo && xi <= hi)
            return sdh_pkg::AXIS_CENTRE;
        if (xi > hi)
        begin
            span = int'(sdh_pkg::AXIS_FULL) - hi;
            if (span == 0)
                return sdh_pkg::AXIS_FULL;
            return sdh_pkg::AXIS_W'(int'(sdh_pkg::AXIS_CENTRE)
                + (xi - hi) * (int'(sdh_pkg::AXIS_FULL) - int'(sdh_pkg::AXIS_CENTRE))
                / span);
        end
        // lower branch: the span is never zero here, guard it all the same
        span = lo;
        if (span == 0)
            return sdh_pkg::AXIS_CENTRE;
        return sdh_pkg::AXIS_W'(int'(sdh_pkg::AXIS_CENTRE)
            - (lo - xi) * int'(sdh_pkg::AXIS_CENTRE) / span);
    endfunction

    // Form direction bits from the raw axes and name the hat position
    function automatic logic [sdh_pkg::HAT_W-1:0] hat_from_axes(
            logic [sdh_pkg::AXIS_W-1:0] a,
            logic [sdh_pkg::AXIS_W-1:0] b,
            logic [sdh_pkg::CFG_W-1:0] thr);
        logic [3:0] dirs;
        int         up_lim;
        int         dn_lim;
        up_lim = int'(sdh_pkg::AXIS_CENTRE) + int'(thr);
        dn_lim = int'(sdh_pkg::AXIS_CENTRE) - int'(thr);
        dirs   = '0;
        if (int'(a) > up_lim)
            dirs = dirs | sdh_pkg::DIR_UP;
        else if (int'(a) < dn_lim)
            dirs = dirs | sdh_pkg::DIR_DOWN;
        if (int'(b) > up_lim)
            dirs = dirs | sdh_pkg::DIR_LEFT;
        else if (int'(b) < dn_lim)
            dirs = dirs | sdh_pkg::DIR_RIGHT;
        case (dirs)
            sdh_pkg::DIR_UP:                        return sdh_pkg::HAT_N;
            sdh_pkg::DIR_UP | sdh_pkg::DIR_RIGHT:   return sdh_pkg::HAT_NE;
            sdh_pkg::DIR_RIGHT:                     return sdh_pkg::HAT_E;
            sdh_pkg::DIR_DOWN | sdh_pkg::DIR_RIGHT: return sdh_pkg::HAT_SE;
            sdh_pkg::DIR_DOWN:                      return sdh_pkg::HAT_S;
            sdh_pkg::DIR_DOWN | sdh_pkg::DIR_LEFT:  return sdh_pkg::HAT_SW;
            sdh_pkg::DIR_LEFT:                      return sdh_pkg::HAT_W_;
            sdh_pkg::DIR_UP | sdh_pkg::DIR_LEFT:    return sdh_pkg::HAT_NW;
            default:                                return sdh_pkg::HAT_NONE;
        endcase
    endfunction

    function automatic stick_out_t predict_stick(logic [sdh_pkg::AXIS_W-1:0] a,
                                                 logic [sdh_pkg::AXIS_W-1:0] b);
        stick_out_t r;
        r.value_a  = shape_axis(a, shadow_deadzone);
        r.value_b  = shape_axis(b, shadow_deadzone);
        r.hat_code = hat_from_axes(a, b, shadow_threshold);
        return r;
    endfunction

    // Draw an axis sample, biased towards the deadzone and threshold edges
    function automatic logic [sdh_pkg::AXIS_W-1:0] pick_axis();
        int v;
        int side;
        side = ($urandom_range(0, 1) == 0) ? 1 : -1;
        case ($urandom_range(0, 5))
            0: v = int'(sdh_pkg::AXIS_CENTRE) + side * int'(shadow_deadzone)
                   + int'($urandom_range(0, 2)) - 1;
            1: v = int'(sdh_pkg::AXIS_CENTRE) + side * int'(shadow_threshold)
                   + int'($urandom_range(0, 2)) - 1;
            2: v = ($urandom_range(0, 1) == 0) ? 0 : int'(sdh_pkg::AXIS_FULL);
            default: v = int'($urandom_range(0, 255));
        endcase
        if (v < 0)
            v = 0;
        if (v > int'(sdh_pkg::AXIS_FULL))
            v = int'(sdh_pkg::AXIS_FULL);
        return sdh_pkg::AXIS_W'(v);
    endfunction

    // Offer one sample pair after a random gap; log the expectation on accept
    task automatic send_pair(input logic [sdh_pkg::AXIS_W-1:0] a,
                             input logic [sdh_pkg::AXIS_W-1:0] b,
                             input stick_out_t want);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.axis_a <= a;
        sample_ch.axis_b <= b;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_outputs.push_back(want);
    endtask

    // Drop the sample request and wait until every result is back
    task automatic drain_pipeline();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_register(input logic [sdh_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [sdh_pkg::CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == sdh_pkg::REG_DEADZONE)
            shadow_deadzone = val;
        else if (idx == sdh_pkg::REG_HAT_THRESHOLD)
            shadow_threshold = val;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random stalls, and one long hold-off on request
    initial
    begin
        int   wait_n;
        logic held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_n = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_go && !held)
            begin
                wait_n = HOLD_OFF_CYCLES;
                held   = 1'b1;
            end
            if (wait_n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        stick_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result: value_a %0d value_b %0d hat_code %0d",
                       result_ch.value_a, result_ch.value_b, result_ch.hat_code);
                fail_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result_ch.value_a !== want.value_a)
                begin
                    $error("value_a: expected %0d, got %0d", want.value_a, result_ch.value_a);
                    fail_count++;
                end
                if (result_ch.value_b !== want.value_b)
                begin
                    $error("value_b: expected %0d, got %0d", want.value_b, result_ch.value_b);
                    fail_count++;
                end
                if (result_ch.hat_code !== want.hat_code)
                begin
                    $error("hat_code: expected %0d, got %0d",
                           want.hat_code, result_ch.hat_code);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[stick_deadzone_and_hat] ERROR");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [sdh_pkg::CFG_W-1:0]  dz_pick;
        logic [sdh_pkg::CFG_W-1:0]  thr_pick;
        logic [sdh_pkg::AXIS_W-1:0] a;
        logic [sdh_pkg::AXIS_W-1:0] b;

        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.axis_a <= '0;
        sample_ch.axis_b <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;

        plan = '{
            // reset settings: centre, corners, deadzone edges
            '{ROW_SAMPLE, '0, '0, 8'd127, 8'd127, 1'b1,
              '{8'd127, 8'd127, sdh_pkg::HAT_NONE}},
            '{ROW_SAMPLE, '0, '0, 8'd255, 8'd255, 1'b1,
              '{8'd255, 8'd255, sdh_pkg::HAT_NW}},
            '{ROW_SAMPLE, '0, '0, 8'd0,   8'd0,   1'b1,
              '{8'd0,   8'd0,   sdh_pkg::HAT_SE}},
            '{ROW_SAMPLE, '0, '0, 8'd255, 8'd0,   1'b1,
              '{8'd255, 8'd0,   sdh_pkg::HAT_NE}},
            '{ROW_SAMPLE, '0, '0, 8'd0,   8'd255, 1'b1,
              '{8'd0,   8'd255, sdh_pkg::HAT_SW}},
            '{ROW_SAMPLE, '0, '0, 8'd177, 8'd77,  1'b1,
              '{8'd127, 8'd127, sdh_pkg::HAT_NONE}},
            '{ROW_SAMPLE, '0, '0, 8'd178, 8'd76,  1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd200, 8'd127, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd127, 8'd20,  1'b0, '0},
            // both registers at their maximum
            '{ROW_WRITE, sdh_pkg::REG_DEADZONE,      7'd127, '0, '0, 1'b0, '0},
            '{ROW_WRITE, sdh_pkg::REG_HAT_THRESHOLD, 7'd127, '0, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd255, 8'd254, 1'b1,
              '{8'd255, 8'd127, sdh_pkg::HAT_N}},
            '{ROW_SAMPLE, '0, '0, 8'd0,   8'd255, 1'b1,
              '{8'd127, 8'd255, sdh_pkg::HAT_W_}},
            '{ROW_SAMPLE, '0, '0, 8'd0,   8'd0,   1'b1,
              '{8'd127, 8'd127, sdh_pkg::HAT_NONE}},
            // no deadzone, no threshold
            '{ROW_WRITE, sdh_pkg::REG_DEADZONE,      7'd0, '0, '0, 1'b0, '0},
            '{ROW_WRITE, sdh_pkg::REG_HAT_THRESHOLD, 7'd0, '0, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd128, 8'd126, 1'b1,
              '{8'd128, 8'd126, sdh_pkg::HAT_NE}},
            '{ROW_SAMPLE, '0, '0, 8'd126, 8'd128, 1'b1,
              '{8'd126, 8'd128, sdh_pkg::HAT_SW}},
            '{ROW_SAMPLE, '0, '0, 8'd127, 8'd127, 1'b1,
              '{8'd127, 8'd127, sdh_pkg::HAT_NONE}},
            // writes to unused indexes must leave the settings alone
            '{ROW_WRITE, REG_SPARE, 7'd3, '0, '0, 1'b0, '0},
            '{ROW_WRITE, 4'(sdh_pkg::REG_HAT_THRESHOLD + 1), 7'd127, '0, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd0,   8'd255, 1'b0, '0},
            // deadzone of 126, threshold of 1
            '{ROW_WRITE, sdh_pkg::REG_DEADZONE,      7'd126, '0, '0, 1'b0, '0},
            '{ROW_WRITE, sdh_pkg::REG_HAT_THRESHOLD, 7'd1,   '0, '0, 1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd255, 8'd0,   1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd254, 8'd1,   1'b0, '0},
            '{ROW_SAMPLE, '0, '0, 8'd129, 8'd125, 1'b0, '0}
        };

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain_pipeline();
                write_register(plan[i].index, plan[i].data);
            end
            else
            begin
                send_pair(plan[i].axis_a, plan[i].axis_b,
                          plan[i].typed ? plan[i].want
                                        : predict_stick(plan[i].axis_a, plan[i].axis_b));
            end
        end

        // Random phases, each under its own register settings
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipeline();
            case (phase)
                0:
                begin
                    dz_pick  = 7'd0;
                    thr_pick = 7'(CFG_MAX);
                end
                1:
                begin
                    dz_pick  = 7'(CFG_MAX);
                    thr_pick = 7'd0;
                end
                2:
                begin
                    dz_pick  = 7'd126;
                    thr_pick = 7'($urandom_range(0, CFG_MAX));
                end
                default:
                begin
                    dz_pick  = 7'($urandom_range(0, CFG_MAX));
                    thr_pick = 7'($urandom_range(0, CFG_MAX));
                end
            endcase
            write_register(sdh_pkg::REG_DEADZONE, dz_pick);
            if ($urandom_range(0, 1) == 0)
                write_register(4'($urandom_range(sdh_pkg::REG_HAT_THRESHOLD + 1, REG_SPARE)),
                               7'($urandom));
            write_register(sdh_pkg::REG_HAT_THRESHOLD, thr_pick);

            // phase two: hold off the result side while requests keep coming
            quiet_tx    = (phase == 2 || phase == 3);
            quiet_rx    = (phase == 3);
            hold_off_go = hold_off_go || (phase == 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                a = pick_axis();
                b = pick_axis();
                send_pair(a, b, predict_stick(a, b));
            end
        end

        // Let the pipeline empty, then idle for the tail and report
        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            $error("%0d results never arrived", pending_outputs.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[stick_deadzone_and_hat] OK");
        else
            $display("[stick_deadzone_and_hat] ERROR");
        $finish;
    end

endmodule
